@@ design/fada_pkg.sv @@
// ----------------------------------------------------------------------------
// fada_pkg
// widths, register indexes and constants of the decimating force/accel
// aggregator
// ----------------------------------------------------------------------------
package fada_pkg;

    localparam int FPS_W       = 9;
    localparam int SCALE_W     = 24;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 24;

    localparam int TIME_W      = 64;
    localparam int FORCE_W     = 32;
    localparam int ACCEL_W     = 16;
    localparam int FLAGS_W     = 16;
    localparam int SUM_W       = 41;
    localparam int SQ_W        = 32;
    localparam int ROOT_W      = 32;
    localparam int SREM_W      = 35;
    localparam int PROD_W      = ROOT_W + SCALE_W;
    localparam int TREM_W      = 10;
    localparam int LANES       = 3;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_FPS   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE = 1'd1;

    localparam logic [FPS_W-1:0]   FPS_RESET   = 9'd20;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd1024;

    localparam logic [TREM_W:0]      US_PER_MS  = 11'd1000;
    localparam logic [FORCE_W-1:0]   PEAK_RESET = 32'h8000_0000;

    // sequencer step counts
    localparam logic [5:0] SQ_LAST    = 6'd15;
    localparam logic [5:0] CALC_LAST  = 6'd63;
    localparam logic [5:0] MDIV_STEPS = 6'd41;
    localparam logic [5:0] SQRT_STEPS = 6'd32;
    localparam logic [5:0] MUL_END    = 6'd56;

    typedef logic [ACCEL_W-1:0] lane_t;
    typedef logic [SQ_W-1:0]    lane_prod_t;

endpackage

@@ design/force_accel_decimating_aggregator_top.sv @@
// ----------------------------------------------------------------------------
// force_accel_decimating_aggregator_top
// every frame: accept, 16 bit-serial squaring steps, then an update
// last frame of a window: a further 64 digit-serial steps (time / 1000
//   sets the length), then a done state that loads the output register once it is free
// next frame accepted once the result sits in the output register
// rst_n clears all control state, accumulators and the two registers
//   (frames_per_sample = 20, accel_scale = 1024); no clearing pass
// ----------------------------------------------------------------------------
module force_accel_decimating_aggregator_top
    import fada_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [TIME_W-1:0]          time_us,
    input  logic signed [FORCE_W-1:0]  force_mean_in,
    input  logic signed [FORCE_W-1:0]  force_peak_in,
    input  logic signed [ACCEL_W-1:0]  accel_x,
    input  logic signed [ACCEL_W-1:0]  accel_y,
    input  logic signed [ACCEL_W-1:0]  accel_z,
    input  logic [FLAGS_W-1:0]         frame_flags,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [31:0]                time_ms,
    output logic signed [FORCE_W-1:0]  force_mean_out,
    output logic signed [FORCE_W-1:0]  force_peak_out,
    output logic [31:0]                peak_accel_g,
    output logic [FLAGS_W-1:0]         flags_union,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;   // waiting for a frame or a config write
    localparam logic [2:0] S_SQ   = 3'd1;   // three shift-add squarers, lsb first
    localparam logic [2:0] S_UPD  = 3'd2;   // sum of squares, max, window count
    localparam logic [2:0] S_CALC = 3'd3;   // dividers, root and scaling, one digit a step
    localparam logic [2:0] S_DONE = 3'd4;   // hand the sample to the output register

    // control state and accumulators
    logic [2:0]               state_reg, state_next;
    logic [5:0]               step_reg, step_next;
    logic [FPS_W-1:0]         fps_reg, fps_next;
    logic [SCALE_W-1:0]       scale_reg, scale_next;
    logic [FPS_W-1:0]         count_reg, count_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [FORCE_W-1:0] peak_reg, peak_next;
    logic [SQ_W-1:0]          sqmax_reg, sqmax_next;
    logic [FLAGS_W-1:0]       flags_reg, flags_next;
    logic                     out_valid_reg, out_valid_next;

    // datapath shift registers
    logic [TIME_W-1:0]        time_reg, time_next;       // dividend, then quotient
    logic [TREM_W-1:0]        trem_reg, trem_next;
    lane_t                    mcand_reg [LANES];
    lane_t                    mcand_next [LANES];
    lane_t                    mplier_reg [LANES];
    lane_t                    mplier_next [LANES];
    lane_prod_t               sqp_reg [LANES];
    lane_prod_t               sqp_next [LANES];
    logic [SUM_W-1:0]         mdiv_reg, mdiv_next;       // |sum|, then quotient
    logic [FPS_W-1:0]         mrem_reg, mrem_next;
    logic                     mneg_reg, mneg_next;
    logic [SQ_W-1:0]          sqsh_reg, sqsh_next;       // radicand digit pairs
    logic [SREM_W-1:0]        srem_reg, srem_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic [SCALE_W-1:0]       scsh_reg, scsh_next;       // scale bits, lsb first
    logic [PROD_W-1:0]        prod_reg, prod_next;

    // output register
    logic [31:0]              time_ms_reg, time_ms_next;
    logic [FORCE_W-1:0]       mean_out_reg, mean_out_next;
    logic [FORCE_W-1:0]       peak_out_reg, peak_out_next;
    logic [31:0]              mag_out_reg, mag_out_next;
    logic [FLAGS_W-1:0]       flags_out_reg, flags_out_next;

    // combinational helpers
    logic                     in_take;
    logic                     cfg_take;
    logic                     out_free;
    lane_t                    in_abs [LANES];
    logic [ACCEL_W:0]         lane_sum [LANES];
    logic [SQ_W-1:0]          sq_total;
    logic [SQ_W-1:0]          sq_best;
    logic [FPS_W-1:0]         count_inc;
    logic [SUM_W-1:0]         sum_abs;
    logic [TREM_W:0]          t_trial;
    logic                     t_ge;
    logic [FPS_W:0]           m_trial;
    logic                     m_ge;
    logic [SREM_W-1:0]        s_shift;
    logic [SREM_W-1:0]        s_trial;
    logic                     s_ge;
    logic [ROOT_W:0]          p_sum;
    logic [SUM_W-1:0]         mean_full;

    // a register write on offer takes the idle cycle, the frame waits
    assign in_stall  = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign time_ms        = time_ms_reg;
    assign force_mean_out = mean_out_reg;
    assign force_peak_out = peak_out_reg;
    assign peak_accel_g   = mag_out_reg;
    assign flags_union    = flags_out_reg;

    // magnitudes of the raw axes; the most negative code gives 32768
    always_comb
    begin
        in_abs[0] = accel_x[ACCEL_W-1] ? lane_t'(~accel_x + 1'b1) : lane_t'(accel_x);
        in_abs[1] = accel_y[ACCEL_W-1] ? lane_t'(~accel_y + 1'b1) : lane_t'(accel_y);
        in_abs[2] = accel_z[ACCEL_W-1] ? lane_t'(~accel_z + 1'b1) : lane_t'(accel_z);
    end

    // one shift-add step per lane: add multiplicand at the top, shift right
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            lane_sum[k] = {1'b0, sqp_reg[k][SQ_W-1:ACCEL_W]}
                        + {1'b0, (mplier_reg[k][0] ? mcand_reg[k] : lane_t'(0))};
        end
    end

    // sum of squares fits 32 bits: 3 * 2^30 at most
    assign sq_total  = sqp_reg[0] + sqp_reg[1] + sqp_reg[2];
    assign sq_best   = (sq_total > sqmax_reg) ? sq_total : sqmax_reg;
    assign count_inc = count_reg + 1'b1;
    assign sum_abs   = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;

    // restoring divide of the timestamp by 1000, one quotient bit a step
    assign t_trial = {trem_reg, time_reg[TIME_W-1]};
    assign t_ge    = (t_trial >= US_PER_MS);

    // restoring divide of |sum| by the window length
    assign m_trial = {mrem_reg, mdiv_reg[SUM_W-1]};
    assign m_ge    = (m_trial >= {1'b0, fps_reg});

    // square root of sqmax * 2^32, two radicand bits a step
    assign s_shift = {srem_reg[SREM_W-3:0], sqsh_reg[SQ_W-1:SQ_W-2]};
    assign s_trial = {1'b0, root_reg, 2'b01};
    assign s_ge    = (s_shift >= s_trial);

    // root times scale, one scale bit a step
    assign p_sum = {1'b0, prod_reg[PROD_W-1:SCALE_W]}
                 + {1'b0, (scsh_reg[0] ? root_reg : ROOT_W'(0))};

    // sign restore; the low 32 bits are the truncated mean
    assign mean_full = mneg_reg ? (~mdiv_reg + 1'b1) : mdiv_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        fps_next       = fps_reg;
        scale_next     = scale_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        peak_next      = peak_reg;
        sqmax_next     = sqmax_reg;
        flags_next     = flags_reg;
        out_valid_next = out_valid_reg;

        time_next  = time_reg;
        trem_next  = trem_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        sqp_next   = sqp_reg;
        mdiv_next  = mdiv_reg;
        mrem_next  = mrem_reg;
        mneg_next  = mneg_reg;
        sqsh_next  = sqsh_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        scsh_next  = scsh_reg;
        prod_next  = prod_reg;

        time_ms_next   = time_ms_reg;
        mean_out_next  = mean_out_reg;
        peak_out_next  = peak_out_reg;
        mag_out_next   = mag_out_reg;
        flags_out_next = flags_out_reg;

        // the consumer took the sample
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_take)
                begin
                    // any register write restarts the window
                    unique case (cfg_index)
                        REG_FPS:   fps_next   = cfg_data[FPS_W-1:0];
                        REG_SCALE: scale_next = cfg_data[SCALE_W-1:0];
                    endcase
                    count_next = '0;
                    sum_next   = '0;
                    peak_next  = PEAK_RESET;
                    sqmax_next = '0;
                    flags_next = '0;
                end
                else if (in_take && (fps_reg != '0))
                begin
                    // with a zero window length the transaction is dropped
                    sum_next   = sum_reg + {{(SUM_W-FORCE_W){force_mean_in[FORCE_W-1]}},
                                            force_mean_in};
                    peak_next  = (force_peak_in > peak_reg) ? force_peak_in : peak_reg;
                    flags_next = flags_reg | frame_flags;
                    time_next  = time_us;
                    for (int k = 0; k < LANES; k++)
                    begin
                        mcand_next[k]  = in_abs[k];
                        mplier_next[k] = in_abs[k];
                        sqp_next[k]    = '0;
                    end
                    step_next  = '0;
                    state_next = S_SQ;
                end
            end

            S_SQ:
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    sqp_next[k]    = {lane_sum[k], sqp_reg[k][ACCEL_W-1:1]};
                    mplier_next[k] = mplier_reg[k] >> 1;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == SQ_LAST)
                begin
                    state_next = S_UPD;
                end
            end

            S_UPD:
            begin
                sqmax_next = sq_best;
                count_next = count_inc;
                if (count_inc < fps_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    // window complete: load the digit-serial units
                    trem_next  = '0;
                    mdiv_next  = sum_abs;
                    mrem_next  = '0;
                    mneg_next  = sum_reg[SUM_W-1];
                    sqsh_next  = sq_best;
                    srem_next  = '0;
                    root_next  = '0;
                    scsh_next  = scale_reg;
                    prod_next  = '0;
                    step_next  = '0;
                    state_next = S_CALC;
                end
            end

            S_CALC:
            begin
                time_next = {time_reg[TIME_W-2:0], t_ge};
                trem_next = t_ge ? TREM_W'(t_trial - US_PER_MS) : t_trial[TREM_W-1:0];

                if (step_reg < MDIV_STEPS)
                begin
                    mdiv_next = {mdiv_reg[SUM_W-2:0], m_ge};
                    mrem_next = m_ge ? FPS_W'(m_trial - {1'b0, fps_reg})
                                     : m_trial[FPS_W-1:0];
                end

                if (step_reg < SQRT_STEPS)
                begin
                    sqsh_next = {sqsh_reg[SQ_W-3:0], 2'b00};
                    srem_next = s_ge ? (s_shift - s_trial) : s_shift;
                    root_next = {root_reg[ROOT_W-2:0], s_ge};
                end
                else if (step_reg < MUL_END)
                begin
                    // root is final here; scale it bit by bit
                    prod_next = {p_sum, prod_reg[SCALE_W-1:1]};
                    scsh_next = scsh_reg >> 1;
                end

                step_next = step_reg + 1'b1;
                if (step_reg == CALC_LAST)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    time_ms_next   = time_reg[31:0];
                    mean_out_next  = mean_full[FORCE_W-1:0];
                    peak_out_next  = peak_reg;
                    mag_out_next   = prod_reg[PROD_W-1:SCALE_W];
                    flags_out_next = flags_reg;
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    sum_next       = '0;
                    peak_next      = PEAK_RESET;
                    sqmax_next     = '0;
                    flags_next     = '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state, registers and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            fps_reg       <= FPS_RESET;
            scale_reg     <= SCALE_RESET;
            count_reg     <= '0;
            sum_reg       <= '0;
            peak_reg      <= PEAK_RESET;
            sqmax_reg     <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            fps_reg       <= fps_next;
            scale_reg     <= scale_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            peak_reg      <= peak_next;
            sqmax_reg     <= sqmax_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and output payload, no reset
    always_ff @(posedge clk)
    begin
        time_reg      <= time_next;
        trem_reg      <= trem_next;
        mcand_reg     <= mcand_next;
        mplier_reg    <= mplier_next;
        sqp_reg       <= sqp_next;
        mdiv_reg      <= mdiv_next;
        mrem_reg      <= mrem_next;
        mneg_reg      <= mneg_next;
        sqsh_reg      <= sqsh_next;
        srem_reg      <= srem_next;
        root_reg      <= root_next;
        scsh_reg      <= scsh_next;
        prod_reg      <= prod_next;
        time_ms_reg   <= time_ms_next;
        mean_out_reg  <= mean_out_next;
        peak_out_reg  <= peak_out_next;
        mag_out_reg   <= mag_out_next;
        flags_out_reg <= flags_out_next;
    end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the decimating force/accel aggregator: a directed
// table of frames and register writes, then random windows at many rates and
// scales, with random idling on both streams; every output sample is compared
// field by field with a hand-typed sample or an in-bench model of the window arithmetic
// ----------------------------------------------------------------------------
module testbench;
    import fada_pkg::*;

    localparam int GAP_MAX       = 12;
    localparam int HOLD_CYCLES   = 300;   // long output hold-off, fills the block
    localparam int SETTLE_CYCLES = 40;    // covers one frame still in flight
    localparam int DRAIN_CYCLES  = 100;
    localparam int STALL_LIMIT   = 3000;  // cycles with no transaction at all
    localparam int PRINT_MAX     = 50;

    typedef enum logic {ROW_CFG, ROW_FRAME} row_kind_t;

    // one input frame, in port order
    typedef struct packed {
        logic [TIME_W-1:0]  time_us;
        logic [FORCE_W-1:0] fmean;
        logic [FORCE_W-1:0] fpeak;
        logic [ACCEL_W-1:0] ax;
        logic [ACCEL_W-1:0] ay;
        logic [ACCEL_W-1:0] az;
        logic [FLAGS_W-1:0] flags;
    } frame_t;

    // one output sample
    typedef struct packed {
        logic [31:0]        time_ms;
        logic [FORCE_W-1:0] fmean;
        logic [FORCE_W-1:0] fpeak;
        logic [31:0]        mag;
        logic [FLAGS_W-1:0] flags;
    } sample_t;

    // a row of the directed table: a register write or a frame sent reps times
    typedef struct {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        frame_t                 frm;
        int                     reps;
        bit                     typed;   // want holds the sample, typed in by hand
        sample_t                want;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------------
    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic [TIME_W-1:0]          time_us;
    logic signed [FORCE_W-1:0]  force_mean_in;
    logic signed [FORCE_W-1:0]  force_peak_in;
    logic signed [ACCEL_W-1:0]  accel_x;
    logic signed [ACCEL_W-1:0]  accel_y;
    logic signed [ACCEL_W-1:0]  accel_z;
    logic [FLAGS_W-1:0]         frame_flags;
    logic                       out_valid;
    logic                       out_stall;
    logic [31:0]                time_ms;
    logic signed [FORCE_W-1:0]  force_mean_out;
    logic signed [FORCE_W-1:0]  force_peak_out;
    logic [31:0]                peak_accel_g;
    logic [FLAGS_W-1:0]         flags_union;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    force_accel_decimating_aggregator_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .time_us        (time_us),
        .force_mean_in  (force_mean_in),
        .force_peak_in  (force_peak_in),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .accel_z        (accel_z),
        .frame_flags    (frame_flags),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .time_ms        (time_ms),
        .force_mean_out (force_mean_out),
        .force_peak_out (force_peak_out),
        .peak_accel_g   (peak_accel_g),
        .flags_union    (flags_union),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // ------------------------------------------------------------------------
    // model state: registers and window accumulators at the block's widths
    // ------------------------------------------------------------------------
    logic [FPS_W-1:0]          rate_q;
    logic [SCALE_W-1:0]        scale_q;
    logic [FPS_W-1:0]          count_q;
    logic signed [SUM_W-1:0]   fsum_q;
    logic signed [FORCE_W-1:0] peak_q;
    logic [SQ_W-1:0]           sqmax_q;
    logic [FLAGS_W-1:0]        flags_q;

    sample_t   samples_due[$];   // expected samples, oldest first
    stim_row_t dir_tab[$];

    sample_t   seen;
    sample_t   due;

    int        mismatches   = 0;
    int        n_frames     = 0;
    int        n_dropped    = 0;
    int        n_samples    = 0;
    int        n_writes     = 0;
    int        quiet_cycles = 0;

    bit        calm;       // no idling on either side
    bit        hold_req;   // receiver to hold off for HOLD_CYCLES

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_MAX)
            $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic frame_t mk_frame(input logic [63:0] t, input logic [31:0] fm,
                                        input logic [31:0] fp, input logic [15:0] ax,
                                        input logic [15:0] ay, input logic [15:0] az,
                                        input logic [15:0] fl);
        frame_t f;
        f.time_us = t;
        f.fmean   = fm;
        f.fpeak   = fp;
        f.ax      = ax;
        f.ay      = ay;
        f.az      = az;
        f.flags   = fl;
        return f;
    endfunction

    function automatic sample_t mk_sample(input logic [31:0] tm, input logic [31:0] fm,
                                          input logic [31:0] fp, input logic [31:0] mag,
                                          input logic [15:0] fl);
        sample_t s;
        s.time_ms = tm;
        s.fmean   = fm;
        s.fpeak   = fp;
        s.mag     = mag;
        s.flags   = fl;
        return s;
    endfunction

    // floor of the square root, one result bit per step from the top
    function automatic logic [31:0] root_floor(input logic [63:0] v);
        logic [31:0] r;
        logic [63:0] trial;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = {32'b0, r | (32'd1 << b)};
            if (trial * trial <= v)
                r = trial[31:0];
        end
        return r;
    endfunction

    // accumulators back to their empty-window values
    task automatic clear_window();
        count_q = '0;
        fsum_q  = '0;
        peak_q  = PEAK_RESET;
        sqmax_q = '0;
        flags_q = '0;
    endtask

    // fold one accepted frame into the window; emit is set when it closes one
    task automatic absorb_frame(input frame_t f, output bit emit, output sample_t s);
        longint      a;
        longint      b;
        longint      c;
        longint      sq;
        longint      quot;
        logic [63:0] ms;
        logic [63:0] prod;
        logic [31:0] root;
        emit = 1'b0;
        s    = '0;
        if (rate_q == '0)
            return;   // disabled: frame dropped, window untouched
        fsum_q = fsum_q + {{(SUM_W-FORCE_W){f.fmean[FORCE_W-1]}}, f.fmean};
        if ($signed(f.fpeak) > peak_q)
            peak_q = f.fpeak;
        a  = longint'($signed(f.ax));
        b  = longint'($signed(f.ay));
        c  = longint'($signed(f.az));
        sq = a * a + b * b + c * c;   // at most 3 * 2^30, fits 32 bits unsigned
        if (sq > longint'(sqmax_q))
            sqmax_q = sq[31:0];
        flags_q = flags_q | f.flags;
        count_q = count_q + 1'b1;
        if (count_q < rate_q)
            return;
        emit = 1'b1;
        ms   = f.time_us / 64'd1000;
        quot = longint'(fsum_q) / longint'(rate_q);   // truncates toward zero
        root = root_floor({sqmax_q, 32'b0});          // root in Q.16
        prod = {32'b0, root} * {40'b0, scale_q};      // below 2^56, never saturates
        s    = mk_sample(ms[31:0], quot[31:0], peak_q, prod[55:24], flags_q);
        clear_window();
    endtask

    function automatic logic [31:0] pick_force();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2, 3: v = 32'($urandom_range(0, 2000)) - 32'd1000;   // small, either sign
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_accel();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 7))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'($urandom_range(0, 400)) - 16'd200;
            default: ;
        endcase
        return v;
    endfunction

    function automatic frame_t rand_frame();
        logic [63:0] t;
        logic [15:0] fl;
        case ($urandom_range(0, 7))
            0: t = '1;
            1: t = '0;
            2: t = {32'b0, $urandom_range(0, 99999)};
            default: t = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 3))
            0: fl = '0;
            1: fl = 16'd1 << $urandom_range(0, 15);
            default: fl = 16'($urandom);
        endcase
        return mk_frame(t, pick_force(), pick_force(), pick_accel(), pick_accel(),
                        pick_accel(), fl);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus tasks
    // ------------------------------------------------------------------------

    // one input transaction after a random gap; the model runs on acceptance
    task automatic send_frame(input frame_t f, input bit typed, input sample_t want);
        int      gap;
        bit      emit;
        sample_t pred;
        gap = calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        time_us       <= f.time_us;
        force_mean_in <= f.fmean;
        force_peak_in <= f.fpeak;
        accel_x       <= f.ax;
        accel_y       <= f.ay;
        accel_z       <= f.az;
        frame_flags   <= f.flags;
        do @(posedge clk); while (in_stall);
        n_frames++;
        if (rate_q == '0)
            n_dropped++;
        absorb_frame(f, emit, pred);
        if (emit)
            samples_due.push_back(typed ? want : pred);
    endtask

    // one register write; valid stays up when another write follows at once
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] d, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        if (last)
            cfg_valid <= 1'b0;
        n_writes++;
        if (idx == REG_FPS)
            rate_q = d[FPS_W-1:0];
        else
            scale_q = d[SCALE_W-1:0];
        clear_window();
    endtask

    // stop offering frames until every sample is back and the block is quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (samples_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // new rate and scale, then n random frames
    task automatic run_rate_phase(input logic [FPS_W-1:0] rate,
                                  input logic [SCALE_W-1:0] scale, input int n);
        settle();
        // bits above the rate field are junk and must be ignored
        write_reg(REG_FPS, {15'($urandom), rate}, 1'b0);
        write_reg(REG_SCALE, scale, 1'b1);
        repeat (n) send_frame(rand_frame(), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // receiver: per sample a random hold-off, which overlaps the valid phase;
    // on request one long hold-off so the block backs up and stalls its input
    // ------------------------------------------------------------------------
    initial
    begin
        int wait_n;
        out_stall <= 1'b0;
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            wait_n = calm ? 0 : $urandom_range(0, GAP_MAX);
            if (wait_n == 0)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                do @(posedge clk); while (!out_valid);
                repeat (wait_n - 1) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);   // sample taken at this edge
        end
    end

    // ------------------------------------------------------------------------
    // checker: each output transaction against the oldest expected sample
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen = mk_sample(time_ms, force_mean_out, force_peak_out, peak_accel_g,
                             flags_union);
            n_samples++;
            if (samples_due.size() == 0)
                report_mismatch($sformatf("sample with nothing expected, time_ms %h",
                                          seen.time_ms));
            else
            begin
                due = samples_due.pop_front();
                if (seen.time_ms !== due.time_ms)
                    report_mismatch($sformatf("time_ms got %h want %h",
                                              seen.time_ms, due.time_ms));
                if (seen.fmean !== due.fmean)
                    report_mismatch($sformatf("force_mean_out got %h want %h",
                                              seen.fmean, due.fmean));
                if (seen.fpeak !== due.fpeak)
                    report_mismatch($sformatf("force_peak_out got %h want %h",
                                              seen.fpeak, due.fpeak));
                if (seen.mag !== due.mag)
                    report_mismatch($sformatf("peak_accel_g got %h want %h",
                                              seen.mag, due.mag));
                if (seen.flags !== due.flags)
                    report_mismatch($sformatf("flags_union got %h want %h",
                                              seen.flags, due.flags));
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transaction on any channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles, %0d samples outstanding",
                     STALL_LIMIT, samples_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [FPS_W-1:0] rate;

        // every input known from time zero
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        time_us       <= '0;
        force_mean_in <= '0;
        force_peak_in <= '0;
        accel_x       <= '0;
        accel_y       <= '0;
        accel_z       <= '0;
        frame_flags   <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        calm          = 1'b0;
        hold_req      = 1'b0;

        // model matches the block's reset values
        rate_q  = FPS_RESET;
        scale_q = SCALE_RESET;
        clear_window();

        // directed table
        // window at the reset rate of 20 and reset scale: mean 140 / 20
        dir_tab.push_back('{ROW_FRAME, REG_FPS, '0,
            mk_frame(64'd5_000_999, 32'd7, -32'sd5, 16'd0, 16'd0, 16'd0, 16'h0001), 20,
            1'b1, mk_sample(32'd5000, 32'd7, -32'sd5, 32'd0, 16'h0001)});
        dir_tab.push_back('{ROW_CFG, REG_FPS, 24'd1, '0, 1, 1'b0, '0});
        // 16384 LSB at reset scale is exactly 1 g
        dir_tab.push_back('{ROW_FRAME, REG_FPS, '0,
            mk_frame(64'd0, 32'd1000, 32'd1000, 16'd16384, 16'd0, 16'd0, 16'h0000), 1,
            1'b1, mk_sample(32'd0, 32'd1000, 32'd1000, 32'h0001_0000, 16'h0000)});
        // most negative forces: peak equal to the empty-window peak
        dir_tab.push_back('{ROW_FRAME, REG_FPS, '0,
            mk_frame(64'd999, 32'h8000_0000, 32'h8000_0000, 16'd0, 16'd0, 16'd0,
                     16'hFFFF), 1,
            1'b1, mk_sample(32'd0, 32'h8000_0000, 32'h8000_0000, 32'd0, 16'hFFFF)});
        dir_tab.push_back('{ROW_FRAME, REG_FPS, '0,
            mk_frame(64'd1000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 16'd0, 16'd0,
                     16'h0000), 1,
            1'b1, mk_sample(32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 16'h0000)});
        // largest magnitude, largest time
        dir_tab.push_back('{ROW_FRAME, REG_FPS, '0,
            mk_frame('1, 32'd0, 32'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000), 1,
            1'b0, '0});
        dir_tab.push_back('{ROW_FRAME, REG_FPS, '0,
            mk_frame(64'd123_456, 32'd0, 32'd0, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h0000),
            1, 1'b0, '0});
        // zero scale: magnitude always zero
        dir_tab.push_back('{ROW_CFG, REG_SCALE, 24'd0, '0, 1, 1'b0, '0});
        dir_tab.push_back('{ROW_FRAME, REG_FPS, '0,
            mk_frame(64'd0, 32'd0, 32'd0, 16'h8000, 16'h8000, 16'h8000, 16'h0000), 1,
            1'b1, mk_sample(32'd0, 32'd0, 32'd0, 32'd0, 16'h0000)});
        // full scale
        dir_tab.push_back('{ROW_CFG, REG_SCALE, 24'hFF_FFFF, '0, 1, 1'b0, '0});
        dir_tab.push_back('{ROW_FRAME, REG_FPS, '0,
            mk_frame(64'h0123_4567_89AB_CDEF, -32'sd1, -32'sd1, 16'h7FFF, 16'h7FFF,
                     16'h7FFF, 16'h5A5A), 1, 1'b0, '0});
        // negative mean truncated toward zero: -3 / 2 is -1
        dir_tab.push_back('{ROW_CFG, REG_FPS, 24'd2, '0, 1, 1'b0, '0});
        dir_tab.push_back('{ROW_FRAME, REG_FPS, '0,
            mk_frame(64'd1_000_000, -32'sd3, -32'sd9, 16'd0, 16'd0, 16'd0, 16'h0F00), 1,
            1'b0, '0});
        dir_tab.push_back('{ROW_FRAME, REG_FPS, '0,
            mk_frame(64'd2_000_000, 32'd0, -32'sd7, 16'd0, 16'd0, 16'd0, 16'h00F0), 1,
            1'b1, mk_sample(32'd2000, -32'sd1, -32'sd7, 32'd0, 16'h0FF0)});
        dir_tab.push_back('{ROW_FRAME, REG_FPS, '0,
            mk_frame(64'd3_000_000, 32'd3, 32'd4, 16'd100, 16'd200, 16'd300, 16'h0001), 1,
            1'b0, '0});
        dir_tab.push_back('{ROW_FRAME, REG_FPS, '0,
            mk_frame(64'd4_000_000, 32'd0, 32'd2, -16'sd300, 16'd0, 16'd7, 16'h0002), 1,
            1'b0, '0});
        // rate zero: frames dropped, no sample
        dir_tab.push_back('{ROW_CFG, REG_FPS, 24'hFF_FE00, '0, 1, 1'b0, '0});
        dir_tab.push_back('{ROW_FRAME, REG_FPS, '0,
            mk_frame(64'd77_000, 32'd500, 32'd600, 16'd1, 16'd2, 16'd3, 16'h1234), 3,
            1'b0, '0});
        // junk above the rate field ignored: rate 3
        dir_tab.push_back('{ROW_CFG, REG_FPS, 24'hFF_FE03, '0, 1, 1'b0, '0});
        dir_tab.push_back('{ROW_FRAME, REG_FPS, '0,
            mk_frame(64'd9_000, 32'd1_000_000, 32'd1_000_000, 16'h7FFF, 16'h7FFF,
                     16'h7FFF, 16'h8000), 2, 1'b0, '0});
        // a write in mid-window throws the partial window away
        dir_tab.push_back('{ROW_CFG, REG_SCALE, 24'd1024, '0, 1, 1'b0, '0});
        dir_tab.push_back('{ROW_FRAME, REG_FPS, '0,
            mk_frame(64'd123_456_789, -32'sd1000, 32'd50, -16'sd5, 16'd6, -16'sd7,
                     16'h0101), 3, 1'b0, '0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // walk the table; registers are only touched with the block idle
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(dir_tab[i].idx, dir_tab[i].data, 1'b1);
            end
            else
                repeat (dir_tab[i].reps)
                    send_frame(dir_tab[i].frm, dir_tab[i].typed, dir_tab[i].want);
        end

        // random windows
        // rate 1, no idling, long receiver hold-off: input backs up
        calm     = 1'b1;
        hold_req = 1'b1;
        run_rate_phase(9'd1, SCALE_RESET, 100);
        calm     = 1'b0;
        run_rate_phase(9'd1, 24'hFF_FFFF, 60);
        run_rate_phase(9'd2, SCALE_W'($urandom), 60);
        run_rate_phase(9'd3, 24'd0, 45);
        run_rate_phase(9'd0, SCALE_W'($urandom), 30);
        // short windows, usually ending on a partial one
        repeat (6)
        begin
            rate = FPS_W'($urandom_range(1, 9));
            run_rate_phase(rate, SCALE_W'($urandom),
                           int'(rate) * int'($urandom_range(3, 6))
                           + int'($urandom_range(0, int'(rate) - 1)));
        end
        // one window at the largest register value
        run_rate_phase(9'd511, SCALE_W'($urandom), 511);

        // drain
        in_valid <= 1'b0;
        while (samples_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d frames sent (%0d dropped while disabled), %0d samples checked, %0d writes",
                 n_frames, n_dropped, n_samples, n_writes);
        $display("rates 0 to 511, scales 0 to full, back-to-back traffic and a %0d-cycle hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
